FILE: src/babd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_pkg: shared types and constants of the button accumulator display
// Holds the command and accumulator word types, button bit positions, LED
// codes and the constants of the modulo-10000 reduction.
// ----------------------------------------------------------------------------
package babd_pkg;

	localparam int TOTAL_WIDTH = 32;

	localparam int SW_W    = 8;
	localparam int BTN_W   = 8;
	localparam int DIGIT_W = 16;
	localparam int LED_W   = 16;

	// button bit positions
	localparam int BTN_CENTER = 7;
	localparam int BTN_UP     = 6;
	localparam int BTN_LEFT   = 5;
	localparam int BTN_RIGHT  = 4;

	localparam logic [3:0]       MINUS_NIBBLE = 4'hC;
	localparam logic [LED_W-1:0] LED_CLEARED  = 16'h0000;
	localparam logic [LED_W-1:0] LED_LATCHED  = 16'h0001;
	localparam logic [LED_W-1:0] LED_ADD      = 16'h0010;
	localparam logic [LED_W-1:0] LED_SUB      = 16'h0020;

	// modulo-10000 reduction: fold bytes with weights 256^k mod 10000,
	// then divide the folded sum by a reciprocal multiply
	localparam int     DEC_MOD     = 10000;
	localparam int     NBYTES      = (TOTAL_WIDTH + 7) / 8;
	localparam int     MAG_EXT_W   = NBYTES * 8;
	localparam longint FOLD_MAX    = 64'd255 * (DEC_MOD - 1) * NBYTES;
	localparam int     FOLD_W      = $clog2(FOLD_MAX + 1);
	localparam int     RECIP_SHIFT = 30;
	localparam longint RECIP_M     = (64'd1 << RECIP_SHIFT) / DEC_MOD;
	localparam int     RECIP_W     = 17;
	localparam int     Q_W         = FOLD_W - 13;
	localparam int     PROD_W      = FOLD_W + RECIP_W;
	localparam int     REM_W       = 14;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		OP_UP     = 4'b0001,
		OP_CENTER = 4'b0010,
		OP_LEFT   = 4'b0100,
		OP_RIGHT  = 4'b1000
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [SW_W-1:0] sw;
	} cmd_t;

	typedef struct packed {
		op_t                    op;
		logic [TOTAL_WIDTH-1:0] total;
	} acc_t;

endpackage

FILE: src/babd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_front: button edge detection and command classification
// Takes one switch/button poll per cycle unless the queue is full, keeps the
// previous button levels and queues one command per poll with a new press.
// ----------------------------------------------------------------------------
module babd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [babd_pkg::SW_W-1:0]  switches,
	input  logic [babd_pkg::BTN_W-1:0] buttons,
	output logic                       push_valid,
	output babd_pkg::cmd_t             push_cmd,
	input  logic                       queue_full
);
	import babd_pkg::*;

	logic [BTN_W-1:0] prev_btn_q;
	logic [BTN_W-1:0] edge_bits;
	logic             accept;
	logic             any_press;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign edge_bits = buttons & ~prev_btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= '0;
		end else if (accept) begin
			prev_btn_q <= buttons;
		end
	end

	// up wins, then center, left, right
	always_comb begin
		push_cmd.sw = switches;
		push_cmd.op = OP_UP;
		any_press   = 1'b1;
		priority if (edge_bits[BTN_UP]) begin
			push_cmd.op = OP_UP;
		end else if (edge_bits[BTN_CENTER]) begin
			push_cmd.op = OP_CENTER;
		end else if (edge_bits[BTN_LEFT]) begin
			push_cmd.op = OP_LEFT;
		end else if (edge_bits[BTN_RIGHT]) begin
			push_cmd.op = OP_RIGHT;
		end else begin
			any_press = 1'b0;
		end
	end

	assign push_valid = accept && any_press;

endmodule

FILE: src/babd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_queue: short command queue
// Decouples the front from the execution pipeline so each side stalls alone.
// ----------------------------------------------------------------------------
module babd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  babd_pkg::cmd_t push_data,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop_ready,
	output babd_pkg::cmd_t pop_data
);
	import babd_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/babd_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_exec: accumulator execution stage
// Pops commands, updates the running total and latched operand, and hands
// the new total with its operation to the display encoder.
// ----------------------------------------------------------------------------
module babd_exec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  babd_pkg::cmd_t cmd,
	output logic           acc_valid,
	input  logic           acc_ready,
	output babd_pkg::acc_t acc
);
	import babd_pkg::*;

	logic [TOTAL_WIDTH-1:0] total_q;
	logic [SW_W-1:0]        operand_q;
	logic [TOTAL_WIDTH-1:0] next_total;
	logic [SW_W-1:0]        next_operand;
	logic                   valid_s1;
	acc_t                   acc_s1;
	logic                   take;

	assign cmd_ready = !valid_s1 || acc_ready;
	assign take      = cmd_valid && cmd_ready;
	assign acc_valid = valid_s1;
	assign acc       = acc_s1;

	always_comb begin
		next_total   = total_q;
		next_operand = operand_q;
		unique case (cmd.op)
			OP_UP: begin
				next_total   = '0;
				next_operand = '0;
			end
			OP_CENTER: begin
				next_operand = cmd.sw;
			end
			OP_LEFT: begin
				next_total = total_q + TOTAL_WIDTH'(operand_q);
			end
			OP_RIGHT: begin
				next_total = total_q - TOTAL_WIDTH'(operand_q);
			end
			default: begin
				next_total = total_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			operand_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (take) begin
				total_q   <= next_total;
				operand_q <= next_operand;
			end
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_s1.op    <= cmd.op;
			acc_s1.total <= next_total;
		end
	end

endmodule

FILE: src/babd_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// babd_encode: display word encoder pipeline
// Magnitude, modulo 10000 by byte folding and reciprocal division, then
// four BCD digits by shift-and-add-3 over two stages; holds the output word.
// ----------------------------------------------------------------------------
module babd_encode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc_valid,
	output logic                         acc_ready,
	input  babd_pkg::acc_t               acc,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [babd_pkg::DIGIT_W-1:0] digit_word,
	output logic [babd_pkg::LED_W-1:0]   led_bits
);
	import babd_pkg::*;

	localparam int DD_HALF = REM_W / 2;

	function automatic logic [13:0] byte_weight(input int k);
		int w;
		w = 1;
		for (int i = 0; i < k; i++) begin
			w = (w * 256) % DEC_MOD;
		end
		return 14'(w);
	endfunction

	// one shift-and-add-3 step per incoming bit, MSB first
	function automatic logic [DIGIT_W-1:0] dabble(input logic [DIGIT_W-1:0] bcd_in,
			input logic [DD_HALF-1:0] bits);
		logic [DIGIT_W-1:0] b;
		b = bcd_in;
		for (int i = DD_HALF - 1; i >= 0; i--) begin
			for (int n = 0; n < 4; n++) begin
				if (b[n*4 +: 4] >= 4'd5) begin
					b[n*4 +: 4] = b[n*4 +: 4] + 4'd3;
				end
			end
			b = {b[DIGIT_W-2:0], bits[i]};
		end
		return b;
	endfunction

	logic v2, v3, v4, v5, v6, v7;
	logic rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	op_t                    op_s2, op_s3, op_s4, op_s5, op_s6;
	logic                   neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [TOTAL_WIDTH-1:0] mag_s2;
	logic [FOLD_W-1:0]      fold_s3, fold_s4;
	logic [Q_W-1:0]         q_s4;
	logic [REM_W-1:0]       rem_s5;
	logic [DIGIT_W-1:0]     bcd_s6;
	logic [DD_HALF-1:0]     low_s6;
	logic [DIGIT_W-1:0]     digit_s7;
	logic [LED_W-1:0]       led_s7;
	logic [DIGIT_W-1:0]     shown_hi_q;

	logic                   neg_in;
	logic [MAG_EXT_W-1:0]   mag_ext;
	logic [FOLD_W-1:0]      fold_sum;
	logic [PROD_W-1:0]      prod;
	logic [FOLD_W-1:0]      qm;
	logic [FOLD_W-1:0]      diff;
	logic [FOLD_W-1:0]      rem_fix;
	logic [DIGIT_W-1:0]     bcd_full;
	logic [DIGIT_W-1:0]     enc;

	assign rdy7 = !v7 || out_ready;
	assign rdy6 = !v6 || rdy7;
	assign rdy5 = !v5 || rdy6;
	assign rdy4 = !v4 || rdy5;
	assign rdy3 = !v3 || rdy4;
	assign rdy2 = !v2 || rdy3;
	assign acc_ready = rdy2;

	assign out_valid  = v7;
	assign digit_word = digit_s7;
	assign led_bits   = led_s7;

	assign neg_in = acc.total[TOTAL_WIDTH-1];

	always_comb begin
		mag_ext  = MAG_EXT_W'(mag_s2);
		fold_sum = '0;
		for (int b = 0; b < NBYTES; b++) begin
			fold_sum = fold_sum + FOLD_W'(mag_ext[b*8 +: 8]) * FOLD_W'(byte_weight(b));
		end
	end

	assign prod    = PROD_W'(fold_s3) * PROD_W'(RECIP_M);
	assign qm      = FOLD_W'(q_s4) * FOLD_W'(DEC_MOD);
	assign diff    = fold_s4 - qm;
	assign rem_fix = (diff >= FOLD_W'(DEC_MOD)) ? diff - FOLD_W'(DEC_MOD) : diff;

	assign bcd_full = dabble(bcd_s6, low_s6);
	assign enc      = neg_s6 ? {MINUS_NIBBLE, bcd_full[DIGIT_W-5:0]} : bcd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
			v7 <= 1'b0;
			shown_hi_q <= '0;
		end else begin
			if (rdy2) v2 <= acc_valid;
			if (rdy3) v3 <= v2;
			if (rdy4) v4 <= v3;
			if (rdy5) v5 <= v4;
			if (rdy6) v6 <= v5;
			if (rdy7) v7 <= v6;
			if (rdy7 && v6 && (op_s6 != OP_CENTER)) begin
				shown_hi_q <= enc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && acc_valid) begin
			op_s2  <= acc.op;
			neg_s2 <= neg_in;
			mag_s2 <= neg_in ? (~acc.total + 1'b1) : acc.total;
		end
		if (rdy3 && v2) begin
			op_s3   <= op_s2;
			neg_s3  <= neg_s2;
			fold_s3 <= fold_sum;
		end
		if (rdy4 && v3) begin
			op_s4   <= op_s3;
			neg_s4  <= neg_s3;
			fold_s4 <= fold_s3;
			q_s4    <= prod[RECIP_SHIFT +: Q_W];
		end
		if (rdy5 && v4) begin
			op_s5  <= op_s4;
			neg_s5 <= neg_s4;
			rem_s5 <= rem_fix[REM_W-1:0];
		end
		if (rdy6 && v5) begin
			op_s6  <= op_s5;
			neg_s6 <= neg_s5;
			bcd_s6 <= dabble('0, rem_s5[REM_W-1:DD_HALF]);
			low_s6 <= rem_s5[DD_HALF-1:0];
		end
		if (rdy7 && v6) begin
			unique case (op_s6)
				OP_CENTER: begin
					digit_s7 <= shown_hi_q;
					led_s7   <= LED_LATCHED;
				end
				OP_UP: begin
					digit_s7 <= enc;
					led_s7   <= LED_CLEARED;
				end
				OP_LEFT: begin
					digit_s7 <= enc;
					led_s7   <= LED_ADD;
				end
				OP_RIGHT: begin
					digit_s7 <= enc;
					led_s7   <= LED_SUB;
				end
				default: begin
					digit_s7 <= enc;
					led_s7   <= LED_CLEARED;
				end
			endcase
		end
	end

endmodule

FILE: src/button_accumulator_bcd_display_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_accumulator_bcd_display_core: button accumulator with BCD display
// Polled switches and buttons drive a 32-bit accumulator; each poll with a
// new press yields one display word with four BCD digits and an LED code.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per poll, switches in bits 7:0 and button
//   levels in bits 15:8 (center 15, up 14, left 13, right 12). A word whose
//   buttons show no new press gives no output word.
//   Output stream (m_*): one word per acting press, digit_word in bits 15:0
//   (four BCD nibbles, top nibble 0xC for minus) and led_bits in 31:16.
//   Throughput: one input word per cycle, sustained while s_tready is high;
//   one output word per cycle while m_tready is high. A taken input word
//   passes the command queue, the execute stage and the encoder pipeline
//   (magnitude, byte fold, reciprocal multiply, remainder, two
//   shift-and-add-3 stages, the second one driving m_*) on its way to m_*.
//   Stall: when m_tready is low the pipeline holds; the 4-entry command
//   queue fills and s_tready drops once it is full. Words that carry no
//   press still need a free queue slot to be taken.
//   Reset: arst_n clears the total, operand, button history, shown digits
//   and all valid flags; no word is sent at reset.
// ----------------------------------------------------------------------------
module button_accumulator_bcd_display_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // switches[7:0], buttons[15:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // digit_word[15:0], led_bits[31:16]
);
	import babd_pkg::*;

	// front to queue
	logic push_valid;
	cmd_t push_cmd;
	logic queue_full;

	// queue to execution
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// execution to encoder
	logic acc_valid;
	logic acc_ready;
	acc_t acc;

	logic [DIGIT_W-1:0] digit_word;
	logic [LED_W-1:0]   led_bits;

	// detect new presses and classify by priority
	babd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.switches   (s_tdata[SW_W-1:0]),
		.buttons    (s_tdata[SW_W +: BTN_W]),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// hold commands while the back end stalls
	babd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_cmd),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_cmd)
	);

	// update total and operand in command order
	babd_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc)
	);

	// convert total to display digits and drive the output word
	babd_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc_valid  (acc_valid),
		.acc_ready  (acc_ready),
		.acc        (acc),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.digit_word (digit_word),
		.led_bits   (led_bits)
	);

	assign m_tdata = {led_bits, digit_word};

endmodule
